FILE: design/rra_pkg.sv
// Shared types and constants for the receiver-report rate adaptation advisor.
// Used by rra_smoother and rtcp_rate_adaptation_advisor; depends on nothing.
package rra_pkg;

    // Field widths.
    localparam int DELAY_W = 24;
    localparam int LOSS_W  = 8;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;

    // Advice codes.
    typedef enum logic [1:0] {
        ADV_NONE          = 2'd0,
        ADV_DECREASE      = 2'd1,
        ADV_INCREASE      = 2'd2,
        ADV_INCREASE_MORE = 2'd3
    } advice_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LIMIT    = 1'b1;

    // Configuration reset values.
    localparam logic [LOSS_W-1:0]  LOSS_THRESHOLD_RST = 8'd30;
    localparam logic [DELAY_W-1:0] DELAY_LIMIT_RST    = 24'd100;

    // Default period lengths in reports.
    localparam int DEF_SHORT_PERIOD = 4;
    localparam int DEF_LONG_PERIOD  = 16;

    // Divide by ten for values below 2^28: floor(x * ceil(2^31 / 10) / 2^31).
    localparam int SUM9_W = 28;
    localparam int DIV10_SHIFT = 31;
    localparam logic [SUM9_W-1:0] DIV10_MUL = 28'hCCCCCCD;

endpackage

FILE: design/rra_smoother.sv
// Smoothed round trip delay register with its (9*old + new) / 10 update.
// Depends on rra_pkg for widths and the divide-by-ten constants.
module rra_smoother
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [rra_pkg::DELAY_W-1:0]  delay,
    output logic [rra_pkg::DELAY_W-1:0]  smoothed,
    output logic [rra_pkg::DELAY_W-1:0]  smoothed_next
);

    localparam int PROD_W = 2 * rra_pkg::SUM9_W;

    logic [rra_pkg::DELAY_W-1:0] smoothed_reg;
    logic [rra_pkg::SUM9_W-1:0]  weighted_sum;
    logic [PROD_W-1:0]           div_prod;
    logic [rra_pkg::DELAY_W-1:0] filtered;

    // Weighted sum 9*old + new always fits in 28 bits.
    assign weighted_sum = {1'b0, smoothed_reg, 3'b000}
                        + {4'b0000, smoothed_reg}
                        + {4'b0000, delay};

    // Divide by ten through the reciprocal constant.
    assign div_prod = {rra_pkg::SUM9_W'(0), weighted_sum}
                    * {rra_pkg::SUM9_W'(0), rra_pkg::DIV10_MUL};
    assign filtered = div_prod[rra_pkg::DIV10_SHIFT +: rra_pkg::DELAY_W];

    // A zero smoothed value is loaded directly by the next report.
    always_comb
    begin
        if (smoothed_reg != '0)
        begin
            smoothed_next = filtered;
        end
        else
        begin
            smoothed_next = delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
        end
        else if (load)
        begin
            smoothed_reg <= smoothed_next;
        end
    end

    assign smoothed = smoothed_reg;

endmodule

FILE: design/rtcp_rate_adaptation_advisor.sv
// A result item is registered in the output register as its input item is accepted.
// Throughput: one item per cycle when the output is not stalled; all state updates in
// the accepting cycle, and the output register takes a new result whenever it is empty or drained.
// Reset: all state, the output valid flag and both configuration registers go
// to their defaults (threshold 30, delay limit 100) at once; no clearing pass.
// Top level of the advisor; depends on rra_pkg and rra_smoother.
module rtcp_rate_adaptation_advisor
#(
    parameter int SHORT_PERIOD = rra_pkg::DEF_SHORT_PERIOD,
    parameter int LONG_PERIOD  = rra_pkg::DEF_LONG_PERIOD
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [rra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rra_pkg::CFG_W-1:0]      cfg_data,
    // Input item channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rra_pkg::DELAY_W-1:0]    round_trip_delay,
    input  logic [rra_pkg::LOSS_W-1:0]     fraction_lost,
    // Result item channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     advice,
    output logic [rra_pkg::DELAY_W-1:0]    smoothed_delay_out
);

    localparam int DW     = rra_pkg::DELAY_W;
    localparam int AVG_C  = (SHORT_PERIOD > 1) ? $clog2(SHORT_PERIOD) : 0;
    localparam int SUM_W  = DW + AVG_C;
    localparam int AVG_K  = DW + 2 * AVG_C;
    localparam int AVG_MW = DW + AVG_C + 1;
    localparam int PROD_W = SUM_W + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_MUL =
        AVG_MW'(((64'd1 << AVG_K) + 64'(SHORT_PERIOD) - 64'd1) / 64'(SHORT_PERIOD));
    localparam int SP_W = (SHORT_PERIOD > 1) ? $clog2(SHORT_PERIOD) : 1;
    localparam int LP_W = (LONG_PERIOD > 1) ? $clog2(LONG_PERIOD) : 1;

    // Configuration registers.
    logic [rra_pkg::LOSS_W-1:0] loss_thr_reg;
    logic [DW-1:0]              delay_limit_reg;

    // Advisor state.
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [DW-1:0]    prev_avg_reg, prev_avg_next;
    logic [SP_W-1:0]  short_phase_reg, short_phase_next;
    logic [LP_W-1:0]  long_phase_reg, long_phase_next;
    logic             adapted_reg, adapted_next;

    // Output register.
    logic             out_valid_reg;
    rra_pkg::advice_t advice_reg, advice_next;
    logic [DW-1:0]    smoothed_out_reg;

    logic             in_fire;
    logic [DW-1:0]    smoothed_cur;
    logic [DW-1:0]    smoothed_upd;
    logic [SUM_W-1:0] sum_plus;
    logic [PROD_W-1:0] avg_prod;
    logic [DW-1:0]    avg;
    logic [DW-1:0]    cmp_ref;
    logic [DW-1:0]    rise, fall;
    logic             loss_high, short_end, long_end;
    logic             delay_dec, delay_inc, advised;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // Smoothed delay filter.
    rra_smoother u_smoother
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_fire),
        .delay         (round_trip_delay),
        .smoothed      (smoothed_cur),
        .smoothed_next (smoothed_upd)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_thr_reg    <= rra_pkg::LOSS_THRESHOLD_RST;
            delay_limit_reg <= rra_pkg::DELAY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rra_pkg::REG_LOSS_THRESHOLD: loss_thr_reg <= cfg_data[rra_pkg::LOSS_W-1:0];
                rra_pkg::REG_DELAY_LIMIT:    delay_limit_reg <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Period sum and truncated average through a reciprocal multiply.
    assign sum_plus = sum_reg + SUM_W'(round_trip_delay);
    assign avg_prod = {AVG_MW'(0), sum_plus} * {SUM_W'(0), AVG_MUL};
    assign avg      = avg_prod[AVG_K +: DW];

    // Period boundaries.
    assign short_end = (short_phase_reg == SP_W'(SHORT_PERIOD - 1));
    assign long_end  = (long_phase_reg == LP_W'(LONG_PERIOD - 1));

    // Delay trend against the previous average, or the smoothed delay.
    assign cmp_ref   = (prev_avg_reg != '0) ? prev_avg_reg : smoothed_upd;
    assign rise      = avg - cmp_ref;
    assign fall      = cmp_ref - avg;
    assign loss_high = (fraction_lost > loss_thr_reg);
    assign delay_dec = short_end && !loss_high && (avg > cmp_ref)
                     && (rise > delay_limit_reg);
    assign delay_inc = short_end && !loss_high && (cmp_ref > avg)
                     && (fall > delay_limit_reg);
    assign advised   = loss_high || delay_dec || delay_inc;

    // Advice selection and next state.
    always_comb
    begin
        if (loss_high || delay_dec)
        begin
            advice_next = rra_pkg::ADV_DECREASE;
        end
        else if (delay_inc)
        begin
            advice_next = rra_pkg::ADV_INCREASE;
        end
        else if (long_end && !adapted_reg)
        begin
            advice_next = rra_pkg::ADV_INCREASE_MORE;
        end
        else
        begin
            advice_next = rra_pkg::ADV_NONE;
        end

        sum_next         = short_end ? '0 : sum_plus;
        prev_avg_next    = short_end ? avg : prev_avg_reg;
        short_phase_next = short_end ? '0 : short_phase_reg + 1'b1;
        long_phase_next  = long_end ? '0 : long_phase_reg + 1'b1;
        adapted_next     = long_end ? 1'b0 : (adapted_reg || advised);
    end

    // State update on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            prev_avg_reg    <= '0;
            short_phase_reg <= '0;
            long_phase_reg  <= '0;
            adapted_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            sum_reg         <= sum_next;
            prev_avg_reg    <= prev_avg_next;
            short_phase_reg <= short_phase_next;
            long_phase_reg  <= long_phase_next;
            adapted_reg     <= adapted_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload is loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            advice_reg       <= advice_next;
            smoothed_out_reg <= smoothed_upd;
        end
    end

    assign out_valid          = out_valid_reg;
    assign advice             = advice_reg;
    assign smoothed_delay_out = smoothed_out_reg;

    // A long-period end always leaves the adapted flag clear.
    a_long_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && long_end) |=> !adapted_reg)
        else $error("adapted flag still set after a long period end");

    // Increase more is only given at a long-period end without adaptation.
    a_more_needs_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && advice_next == rra_pkg::ADV_INCREASE_MORE)
        |-> (long_end && !adapted_reg && !advised))
        else $error("increase more advised during an adapted period");

    // A short-period end restarts the delay sum.
    a_short_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && short_end) |=> (sum_reg == '0 && short_phase_reg == '0))
        else $error("period sum not restarted at short period end");

    // A nonzero report never leaves the smoothed delay at zero.
    a_smooth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && round_trip_delay != '0) |=> (smoothed_cur != '0))
        else $error("smoothed delay zero after a nonzero report");

    // Any advice sets the flag unless the long period ends on this item.
    a_advice_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && advised && !long_end) |=> adapted_reg)
        else $error("advice given without setting the adapted flag");

endmodule
